/* hdl/crpn_pkg.sv */
// Package for the complex RPN stack calculator.
// Holds the func codes, the decoded operation and status codes, the sequencer states
// and the payload structs shared by the interface, front end, back end and top level.
package crpn_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int DEF_STACK_DEPTH = 32;
	localparam int DEF_VALUE_WIDTH = 32;

	// Fixed port widths
	localparam int PORT_WIDTH = 32;
	localparam int FUNC_WIDTH = 4;

	// Command queue between front and back end
	localparam int QUEUE_DEPTH = 2;

	// Raw func codes on the command channel
	localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH  = 4'd0;
	localparam logic [FUNC_WIDTH-1:0] FUNC_ADD   = 4'd1;
	localparam logic [FUNC_WIDTH-1:0] FUNC_SUB   = 4'd2;
	localparam logic [FUNC_WIDTH-1:0] FUNC_MUL   = 4'd3;
	localparam logic [FUNC_WIDTH-1:0] FUNC_NEG   = 4'd4;
	localparam logic [FUNC_WIDTH-1:0] FUNC_DUP   = 4'd5;
	localparam logic [FUNC_WIDTH-1:0] FUNC_SWAP  = 4'd6;
	localparam logic [FUNC_WIDTH-1:0] FUNC_PEEK  = 4'd7;
	localparam logic [FUNC_WIDTH-1:0] FUNC_CLEAR = 4'd8;

	// Decoded operation as queued for the back end
	typedef enum logic [3:0] {
		OP_PUSH,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_NEG,
		OP_DUP,
		OP_SWAP,
		OP_PEEK,
		OP_CLEAR,
		OP_DUMP,
		OP_NOP
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_MUL,
		BK_SWAP2,
		BK_DUMP
	} bk_state_t;

	// Command channel payload
	typedef struct packed {
		logic [FUNC_WIDTH-1:0]        func;
		logic                         dump_all;
		logic signed [PORT_WIDTH-1:0] push_real;
		logic signed [PORT_WIDTH-1:0] push_imag;
	} cmd_item_t;

	// Result channel payload
	typedef struct packed {
		logic [1:0]                   status;
		logic                         has_value;
		logic signed [PORT_WIDTH-1:0] out_real;
		logic signed [PORT_WIDTH-1:0] out_imag;
		logic                         last;
	} rsp_item_t;

	// Queue entry: classified command plus push operand
	typedef struct packed {
		op_t                   op;
		logic [PORT_WIDTH-1:0] val_re;
		logic [PORT_WIDTH-1:0] val_im;
	} q_item_t;

endpackage

/* hdl/crpn_stream_if.sv */
// Valid/ready stream interface used for the command and result channels.
// The payload type is a parameter; the structs come from crpn_pkg.
interface crpn_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/crpn_ram.sv */
// Generic simple RAM: one write port, two read ports, registered read data.
// Read data holds while its read enable is low. No dependencies.
module crpn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re_a,
	input  logic [ADDR_W-1:0] raddr_a,
	output logic [WIDTH-1:0]  rdata_a,
	input  logic              re_b,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* hdl/crpn_front.sv */
// Front end: accepts command transactions, decodes func/dump_all into an operation
// and queues it for the back end. Uses crpn_pkg and crpn_stream_if.
module crpn_front import crpn_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	crpn_stream_if.sink     cmd,
	output logic            q_valid,
	output q_item_t         q_item,
	input  logic            q_pop
);

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              op_dec;
	q_item_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic             push;

	// Decode; dump_all wins over func, unused codes decode to OP_NOP
	always_comb begin
		op_dec = OP_NOP;
		if (cmd.payload.dump_all) begin
			op_dec = OP_DUMP;
		end else begin
			unique case (cmd.payload.func)
				FUNC_PUSH:  op_dec = OP_PUSH;
				FUNC_ADD:   op_dec = OP_ADD;
				FUNC_SUB:   op_dec = OP_SUB;
				FUNC_MUL:   op_dec = OP_MUL;
				FUNC_NEG:   op_dec = OP_NEG;
				FUNC_DUP:   op_dec = OP_DUP;
				FUNC_SWAP:  op_dec = OP_SWAP;
				FUNC_PEEK:  op_dec = OP_PEEK;
				FUNC_CLEAR: op_dec = OP_CLEAR;
				default:    op_dec = OP_NOP;
			endcase
		end
	end

	// Queue handshake
	assign cmd.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (count_q != '0);
	assign q_item    = slot_q[rd_ptr_q];

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{op: op_dec,
				val_re: cmd.payload.push_real,
				val_im: cmd.payload.push_imag};
		end
	end

endmodule

/* hdl/crpn_back.sv */
// Back end: sequencer that executes queued operations on the stack RAM and
// drives the result channel through an output register. Uses crpn_pkg, crpn_stream_if.
module crpn_back import crpn_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
	localparam int RAM_W  = 2 * VALUE_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  q_item_t           q_item,
	output logic              q_pop,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [RAM_W-1:0]  ram_wdata,
	output logic              ram_re_a,
	output logic [ADDR_W-1:0] ram_raddr_a,
	input  logic [RAM_W-1:0]  ram_rdata_a,
	output logic              ram_re_b,
	output logic [ADDR_W-1:0] ram_raddr_b,
	input  logic [RAM_W-1:0]  ram_rdata_b,
	crpn_stream_if.source     rsp
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	bk_state_t               state_q, state_d;
	logic [CNT_W-1:0]        n_q, n_d;
	logic [ADDR_W-1:0]       idx_q, idx_d;
	op_t                     op_q, op_d;
	logic [VALUE_WIDTH-1:0]  p_brar_q, p_biai_q, p_aibr_q, p_arbi_q;
	logic                    mul_load;
	logic                    rsp_valid_q;
	rsp_item_t               rsp_data_q;

	logic                    out_free;
	logic                    emit;
	status_t                 e_status;
	logic                    e_hv;
	logic [VALUE_WIDTH-1:0]  e_re, e_im;
	logic                    e_last;

	logic [CNT_W-1:0]        nm1, nm2;
	logic                    has_one, has_two, full;
	logic [VALUE_WIDTH-1:0]  a_re, a_im, b_re, b_im;

	function automatic logic [PORT_WIDTH-1:0] sext(input logic [VALUE_WIDTH-1:0] v);
		return PORT_WIDTH'(signed'(v));
	endfunction

	// Stack pointer arithmetic and operand views (a = top, b = second)
	assign nm1     = n_q - 1'b1;
	assign nm2     = n_q - CNT_W'(2);
	assign has_one = (n_q != '0);
	assign has_two = (n_q >= CNT_W'(2));
	assign full    = (n_q == CNT_W'(STACK_DEPTH));
	assign a_re    = ram_rdata_a[RAM_W-1:VALUE_WIDTH];
	assign a_im    = ram_rdata_a[VALUE_WIDTH-1:0];
	assign b_re    = ram_rdata_b[RAM_W-1:VALUE_WIDTH];
	assign b_im    = ram_rdata_b[VALUE_WIDTH-1:0];
	assign out_free = !rsp_valid_q || rsp.ready;

	// State register and stack count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
		end
	end

	// Sequencer: next state, RAM control and result generation
	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		idx_d       = idx_q;
		op_d        = op_q;
		q_pop       = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		ram_re_a    = 1'b0;
		ram_raddr_a = nm1[ADDR_W-1:0];
		ram_re_b    = 1'b0;
		ram_raddr_b = nm2[ADDR_W-1:0];
		mul_load    = 1'b0;
		emit        = 1'b0;
		e_status    = ST_OK;
		e_hv        = 1'b0;
		e_re        = '0;
		e_im        = '0;
		e_last      = 1'b1;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					op_d = q_item.op;
					unique case (q_item.op) inside
						OP_PUSH: begin
							if (out_free) begin
								q_pop = 1'b1;
								emit  = 1'b1;
								if (full) begin
									e_status = ST_FULL;
								end else begin
									ram_we    = 1'b1;
									ram_waddr = n_q[ADDR_W-1:0];
									ram_wdata = {q_item.val_re[VALUE_WIDTH-1:0],
										q_item.val_im[VALUE_WIDTH-1:0]};
									n_d       = n_q + 1'b1;
								end
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_SWAP: begin
							if (has_two) begin
								q_pop    = 1'b1;
								ram_re_a = 1'b1;
								ram_re_b = 1'b1;
								state_d  = BK_READ;
							end else if (out_free) begin
								q_pop    = 1'b1;
								emit     = 1'b1;
								e_status = ST_UNDERFLOW;
							end
						end
						OP_NEG, OP_PEEK, OP_DUP: begin
							if (!has_one) begin
								if (out_free) begin
									q_pop    = 1'b1;
									emit     = 1'b1;
									e_status = ST_UNDERFLOW;
								end
							end else if (q_item.op == OP_DUP && full) begin
								if (out_free) begin
									q_pop    = 1'b1;
									emit     = 1'b1;
									e_status = ST_FULL;
								end
							end else begin
								q_pop    = 1'b1;
								ram_re_a = 1'b1;
								state_d  = BK_READ;
							end
						end
						OP_CLEAR: begin
							if (out_free) begin
								q_pop = 1'b1;
								emit  = 1'b1;
								n_d   = '0;
							end
						end
						OP_DUMP: begin
							if (has_one) begin
								q_pop    = 1'b1;
								ram_re_a = 1'b1;
								idx_d    = nm1[ADDR_W-1:0];
								state_d  = BK_DUMP;
							end else if (out_free) begin
								// empty dump: one plain result
								q_pop = 1'b1;
								emit  = 1'b1;
							end
						end
						default: begin
							if (out_free) begin
								q_pop = 1'b1;
								emit  = 1'b1;
							end
						end
					endcase
				end
			end
			BK_READ: begin
				unique case (op_q) inside
					OP_ADD, OP_SUB: begin
						if (out_free) begin
							ram_we    = 1'b1;
							ram_waddr = nm2[ADDR_W-1:0];
							ram_wdata = (op_q == OP_ADD) ? {b_re + a_re, b_im + a_im}
								: {b_re - a_re, b_im - a_im};
							n_d       = nm1;
							emit      = 1'b1;
							state_d   = BK_IDLE;
						end
					end
					OP_MUL: begin
						mul_load = 1'b1;
						state_d  = BK_MUL;
					end
					OP_SWAP: begin
						ram_we    = 1'b1;
						ram_waddr = nm2[ADDR_W-1:0];
						ram_wdata = ram_rdata_a;
						state_d   = BK_SWAP2;
					end
					OP_NEG: begin
						if (out_free) begin
							ram_we    = 1'b1;
							ram_waddr = nm1[ADDR_W-1:0];
							ram_wdata = {VALUE_WIDTH'(0) - a_re, VALUE_WIDTH'(0) - a_im};
							emit      = 1'b1;
							state_d   = BK_IDLE;
						end
					end
					OP_DUP: begin
						if (out_free) begin
							ram_we    = 1'b1;
							ram_waddr = n_q[ADDR_W-1:0];
							ram_wdata = ram_rdata_a;
							n_d       = n_q + 1'b1;
							emit      = 1'b1;
							state_d   = BK_IDLE;
						end
					end
					OP_PEEK: begin
						if (out_free) begin
							emit    = 1'b1;
							e_hv    = 1'b1;
							e_re    = a_re;
							e_im    = a_im;
							state_d = BK_IDLE;
						end
					end
					default: state_d = BK_IDLE;
				endcase
			end
			BK_MUL: begin
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = nm2[ADDR_W-1:0];
					ram_wdata = {p_brar_q - p_biai_q, p_aibr_q + p_arbi_q};
					n_d       = nm1;
					emit      = 1'b1;
					state_d   = BK_IDLE;
				end
			end
			BK_SWAP2: begin
				// old second entry is still held on read port b
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = nm1[ADDR_W-1:0];
					ram_wdata = ram_rdata_b;
					emit      = 1'b1;
					state_d   = BK_IDLE;
				end
			end
			BK_DUMP: begin
				if (out_free) begin
					emit   = 1'b1;
					e_hv   = 1'b1;
					e_re   = a_re;
					e_im   = a_im;
					e_last = (idx_q == '0);
					if (idx_q == '0) begin
						state_d = BK_IDLE;
					end else begin
						ram_re_a    = 1'b1;
						ram_raddr_a = idx_q - 1'b1;
						idx_d       = idx_q - 1'b1;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Output register, valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Payload registers: result, operation, dump index, partial products
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		idx_q <= idx_d;
		if (emit) begin
			rsp_data_q <= '{status: e_status,
				has_value: e_hv,
				out_real: e_hv ? sext(e_re) : '0,
				out_imag: e_hv ? sext(e_im) : '0,
				last: e_last};
		end
		if (mul_load) begin
			p_brar_q <= b_re * a_re;
			p_biai_q <= b_im * a_im;
			p_aibr_q <= a_im * b_re;
			p_arbi_q <= a_re * b_im;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

endmodule

/* hdl/complex_rpn_stack_calculator_top.sv */
// Top level of the complex RPN stack calculator.
// Instantiates crpn_front, crpn_back and crpn_ram; uses crpn_pkg and crpn_stream_if.
//
// Usage:
//   cmd carries one command per transaction (func, dump_all, push_real, push_imag);
//   rsp carries result transactions (status, has_value, out_real, out_imag, last).
//   Every command yields one result with last set, except a dump of a non-empty
//   stack, which yields one result per entry, top first, last set on the bottom one.
//   A two-entry command queue sits between the decoder and the executing sequencer.
//   Steps, from the sequencer taking a command off the queue:
//     push, clear, unused codes and error cases: result as the command is taken
//     add, sub, negate, duplicate, peek: registered stack RAM read, then the result
//     multiply and swap: RAM read, then product register / second RAM write
//     dump: one entry per cycle from the RAM read port, unless rsp stalls
//   Each result appears on rsp in the cycle after the sequencer produces it.
//   Reset empties the stack count, the queue and the output register; the stack
//   RAM is not cleared. When rsp stalls, the result holds in the output register,
//   the sequencer waits on its next result and cmd keeps filling the queue.
module complex_rpn_stack_calculator_top import crpn_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	crpn_stream_if.sink   cmd,
	crpn_stream_if.source rsp
);

	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int RAM_W  = 2 * VALUE_WIDTH;

	logic              q_valid;
	q_item_t           q_item;
	logic              q_pop;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [RAM_W-1:0]  ram_wdata;
	logic              ram_re_a;
	logic [ADDR_W-1:0] ram_raddr_a;
	logic [RAM_W-1:0]  ram_rdata_a;
	logic              ram_re_b;
	logic [ADDR_W-1:0] ram_raddr_b;
	logic [RAM_W-1:0]  ram_rdata_b;

	// Decoder and command queue
	crpn_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// Execution sequencer
	crpn_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re_a    (ram_re_a),
		.ram_raddr_a (ram_raddr_a),
		.ram_rdata_a (ram_rdata_a),
		.ram_re_b    (ram_re_b),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_b (ram_rdata_b),
		.rsp         (rsp)
	);

	// Stack storage, {real, imag} per entry
	crpn_ram #(
		.WIDTH (RAM_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re_a    (ram_re_a),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.re_b    (ram_re_b),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	// The sequencer only takes commands that are queued
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue popped while empty");

	// A stack write never shares a cycle with a stack read
	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> !(ram_re_a || ram_re_b))
		else $error("stack RAM read and write in the same cycle");

	// Results without a value carry zero data
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.payload.has_value) |->
		(rsp.payload.out_real == '0 && rsp.payload.out_imag == '0))
		else $error("result without value has nonzero data");

	// A value-carrying result is always ok
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.has_value) |-> (rsp.payload.status == ST_OK))
		else $error("value-carrying result with error status");

endmodule
